FILE: rtl/crle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_pkg: shared types and constants
// Queue operation codes, input kinds, back-end states and fixed-point
// constants of the RMS level envelope unit.
// ----------------------------------------------------------------------------
package crle_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int RATE_W     = 16;
  localparam int TAU_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEN_W      = RATE_W + TAU_W;
  localparam int Q16_W      = 17;
  localparam int EXP_W      = 5;
  localparam int LOG_W      = EXP_W + 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = 2;

  localparam logic [1:0] KIND_SAMPLE     = 2'd0;
  localparam logic [1:0] KIND_SPEECH_ON  = 2'd1;
  localparam logic [1:0] KIND_SPEECH_OFF = 2'd2;
  localparam logic [1:0] KIND_CLEAR      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELEASE = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET    = 16'd16000;
  localparam logic [TAU_W-1:0]  ATTACK_RESET  = 14'd20;
  localparam logic [TAU_W-1:0]  RELEASE_RESET = 14'd300;

  // log2 of the mean square at -60 dBFS, and 3.0103/45, both in Q16
  localparam logic [LOG_W-1:0] NORM_X0    = 21'd659845;
  localparam logic [12:0]      NORM_SLOPE = 13'd4384;
  localparam logic [Q16_W-1:0] ONE_Q16    = 17'd65536;

  typedef enum logic [1:0] {
    OP_CHUNK     = 2'd0,
    OP_VOICE_ON  = 2'd1,
    OP_VOICE_OFF = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_NRM_SHIFT,
    ST_LOG_SQ,
    ST_NORM,
    ST_TAU_MUL,
    ST_R_GO,
    ST_DIV_R,
    ST_ALPHA_SQ,
    ST_UPDATE,
    ST_LVL_GO,
    ST_DIV_LVL,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_hz;
    logic [TAU_W-1:0]  attack_ms;
    logic [TAU_W-1:0]  release_ms;
  } crle_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/crle_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_if: stream channels
// Input beat channel (kind, sample, chunk_end) and result channel (level).
// ----------------------------------------------------------------------------
interface crle_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic signed [crle_pkg::SAMPLE_W-1:0] sample;
  logic                          chunk_end;
  modport source (output valid, kind, sample, chunk_end, input ready);
  modport sink   (input valid, kind, sample, chunk_end, output ready);
endinterface

interface crle_out_if;
  logic                         valid;
  logic                         ready;
  logic [crle_pkg::LEVEL_W-1:0] level;
  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface
`default_nettype wire

FILE: rtl/crle_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_queue: command queue
// Small FIFO between the accumulating front end and the chunk math back end.
// ----------------------------------------------------------------------------
module crle_queue #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          pop,
  output logic [W-1:0]       rdata,
  output crle_pkg::q_stat_t  stat
);
  import crle_pkg::*;

  logic [W-1:0]    mem_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QA_W:0]   cnt_r;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == (QA_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_front: input front end
// Accumulates the sum of squares of a chunk and queues chunk and event commands.
// ----------------------------------------------------------------------------
module crle_front #(
  parameter int MAX_CNT = 4096,
  parameter int CNT_W   = 13,
  parameter int SUM_W   = 43
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  crle_in_if.sink                       in_beat,
  input  wire crle_pkg::q_stat_t        q_stat,
  output logic                          push,
  output logic [2+SUM_W+CNT_W-1:0]      push_data
);
  import crle_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [16:0]      mag;
  logic [33:0]      sq;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept, chunk_done;

  assign in_beat.ready = !q_stat.full;
  assign accept        = in_beat.valid && in_beat.ready;

  // Magnitude of a signed sample; full-scale negative gives 32768.
  assign mag     = in_beat.sample[SAMPLE_W-1] ? (17'd0 - {1'b1, in_beat.sample})
                                              : {1'b0, in_beat.sample};
  assign sq      = mag * mag;
  assign sum_add = sum_r + SUM_W'(sq[30:0]);
  assign cnt_inc = cnt_r + 1'b1;
  assign chunk_done = in_beat.chunk_end || (cnt_inc == CNT_W'(MAX_CNT));

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_data = {OP_CLEAR, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
    if (accept) begin
      unique case (in_beat.kind)
        KIND_SAMPLE: begin
          if (chunk_done) begin
            push      = 1'b1;
            push_data = {OP_CHUNK, sum_add, cnt_inc};
            sum_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_inc;
          end
        end
        KIND_SPEECH_ON: begin
          push      = 1'b1;
          push_data = {OP_VOICE_ON, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        end
        KIND_SPEECH_OFF: begin
          push      = 1'b1;
          push_data = {OP_VOICE_OFF, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        end
        default: begin
          push      = 1'b1;
          push_data = {OP_CLEAR, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crle_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_div: shared divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crle_div #(
  parameter int DW = 55,
  parameter int VW = 30
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [VW-1:0] rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_r, dvd_r[DW-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};
  assign done    = done_r;
  assign quot    = dvd_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      dvd_r <= {dvd_r[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crle_back: chunk math back end
// Mean square, log2, normalization, attack/release alpha, envelope update and
// displayed level, sequenced over one divider and one 32x32 multiplier.
// ----------------------------------------------------------------------------
module crle_back #(
  parameter int CNT_W = 13,
  parameter int SUM_W = 43
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire crle_pkg::crle_cfg_t     cfg,
  input  wire crle_pkg::q_stat_t       q_stat,
  input  wire logic [2+SUM_W+CNT_W-1:0] q_rdata,
  output logic                         pop,
  crle_out_if.source                   out_beat
);
  import crle_pkg::*;

  localparam int NUM_W = CNT_W + 42;

  back_state_t      state_r, state_nxt;
  op_t              q_op;
  logic [SUM_W-1:0] q_sum;
  logic [CNT_W-1:0] q_cnt;

  logic [CNT_W-1:0] cnt_r;
  logic             voice_r;
  logic [Q16_W-1:0] env_r, norm_r, alpha_r;
  logic             up_r;
  logic [31:0]      x_r;
  logic [EXP_W-1:0] exp_r;
  logic [15:0]      frac_r;
  logic [3:0]       iter_r;
  logic [DEN_W-1:0] den_r;
  logic [LEVEL_W-1:0] res_r;
  logic             out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_dvd, div_quot;
  logic [DEN_W-1:0] div_dvs;
  logic             emit_load;

  logic [63:0]      prod;
  logic [31:0]      log_t;
  logic [LOG_W-1:0] lg;
  logic [33:0]      norm_p;
  logic [17:0]      norm_q;
  logic [RATE_W-1:0] rate1;
  logic [TAU_W-1:0]  tau, tau1;
  logic [Q16_W-1:0] diff_l;
  logic [33:0]      step_p;
  logic [Q16_W-1:0] step_s;
  logic [CNT_W+9:0] cnt_k;
  logic [32:0]      lvl_dvd;
  logic [17:0]      lvl_dvs;
  logic [19:0]      r_step;

  assign q_op  = op_t'(q_rdata[2+SUM_W+CNT_W-1 -: 2]);
  assign q_sum = q_rdata[CNT_W +: SUM_W];
  assign q_cnt = q_rdata[CNT_W-1:0];

  crle_div #(.DW(NUM_W), .VW(DEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Shared squarer for the log2 fraction and for the repeated squaring that approximates exp.
  assign prod   = x_r * x_r;
  assign log_t  = prod[61:30];
  assign lg     = {exp_r, frac_r};
  assign norm_p = (lg - NORM_X0) * NORM_SLOPE;
  assign norm_q = norm_p[33:16];
  assign rate1  = (cfg.rate_hz == '0) ? RATE_W'(1) : cfg.rate_hz;
  assign tau    = (norm_r > env_r) ? cfg.attack_ms : cfg.release_ms;
  assign tau1   = (tau == '0) ? TAU_W'(1) : tau;
  assign diff_l = up_r ? (norm_r - env_r) : (env_r - norm_r);
  assign step_p = alpha_r * diff_l;
  assign step_s = step_p[32:16];
  assign cnt_k  = (CNT_W+10)'(cnt_r) * 10'd1000;
  assign lvl_dvd = {1'b0, env_r, 15'd0} + 33'({1'b0, env_r} + 18'd32768 >> 1);
  assign lvl_dvs = {1'b0, env_r} + 18'd32768;
  assign r_step  = div_quot[35:16];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (q_op == OP_CHUNK)      state_nxt = ST_DIV_MEAN;
          else if (q_op == OP_CLEAR) state_nxt = ST_EMIT;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          state_nxt = (div_quot[NUM_W-1:1] == '0) ? ST_NORM : ST_NRM_SHIFT;
        end
      end
      ST_NRM_SHIFT: if (x_r[30]) state_nxt = ST_LOG_SQ;
      ST_LOG_SQ:    if (iter_r == 4'd15) state_nxt = ST_NORM;
      ST_NORM:      state_nxt = ST_TAU_MUL;
      ST_TAU_MUL:   state_nxt = ST_R_GO;
      ST_R_GO:      state_nxt = ST_DIV_R;
      ST_DIV_R: begin
        if (div_done) begin
          if (div_quot[NUM_W-1:36] != '0 || r_step == '0) state_nxt = ST_UPDATE;
          else                                            state_nxt = ST_ALPHA_SQ;
        end
      end
      ST_ALPHA_SQ:  if (iter_r == 4'd15) state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_LVL_GO;
      ST_LVL_GO:    state_nxt = voice_r ? ST_DIV_LVL : ST_EMIT;
      ST_DIV_LVL:   if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:      if (!out_valid_r || out_beat.ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    div_dvd   = NUM_W'(q_sum);
    div_dvs   = DEN_W'(q_cnt);
    emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop       = !q_stat.empty;
        div_start = !q_stat.empty && (q_op == OP_CHUNK);
      end
      ST_R_GO: begin
        div_start = 1'b1;
        div_dvd   = {cnt_k, 32'd0};
        div_dvs   = den_r;
      end
      ST_LVL_GO: begin
        div_start = voice_r;
        div_dvd   = NUM_W'(lvl_dvd);
        div_dvs   = DEN_W'(lvl_dvs);
      end
      ST_EMIT: emit_load = !out_valid_r || out_beat.ready;
      default: ;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cnt_r <= q_cnt;
        res_r <= '0;
      end
      ST_DIV_MEAN: begin
        x_r    <= {1'b0, div_quot[30:0]};
        exp_r  <= EXP_W'(30);
        frac_r <= '0;
        iter_r <= '0;
        if (div_quot[NUM_W-1:1] == '0) exp_r <= '0;
      end
      ST_NRM_SHIFT: begin
        if (!x_r[30]) begin
          x_r   <= {x_r[30:0], 1'b0};
          exp_r <= exp_r - 1'b1;
        end
      end
      ST_LOG_SQ: begin
        iter_r <= iter_r + 1'b1;
        if (log_t[31]) begin
          x_r    <= {1'b0, log_t[31:1]};
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          x_r    <= log_t;
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      ST_NORM: begin
        if (lg <= NORM_X0)                 norm_r <= '0;
        else if (norm_q > 18'(ONE_Q16))    norm_r <= ONE_Q16;
        else                               norm_r <= norm_q[Q16_W-1:0];
      end
      ST_TAU_MUL: begin
        up_r  <= (norm_r > env_r);
        den_r <= rate1 * tau1;
      end
      ST_DIV_R: begin
        iter_r <= '0;
        x_r    <= 32'(33'h1_0000_0000 - 33'(r_step));
        if (div_quot[NUM_W-1:36] != '0) alpha_r <= ONE_Q16;
        else                            alpha_r <= '0;
      end
      ST_ALPHA_SQ: begin
        iter_r  <= iter_r + 1'b1;
        x_r     <= prod[63:32];
        alpha_r <= ONE_Q16 - {1'b0, prod[63:48]};
      end
      ST_DIV_LVL: res_r <= div_quot[LEVEL_W-1:0];
      default: ;
    endcase
  end

  // Envelope and voice flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r   <= '0;
      voice_r <= 1'b0;
    end else if (state_r == ST_IDLE && !q_stat.empty) begin
      unique case (q_op)
        OP_VOICE_ON:  voice_r <= 1'b1;
        OP_VOICE_OFF: voice_r <= 1'b0;
        OP_CLEAR:     env_r   <= '0;
        default: ;
      endcase
    end else if (state_r == ST_UPDATE) begin
      env_r <= up_r ? (env_r + step_s) : (env_r - step_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_load)           out_valid_r <= 1'b1;
      else if (out_beat.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) out_level_r <= res_r;
  end

  assign out_beat.valid = out_valid_r;
  assign out_beat.level = out_level_r;

endmodule
`default_nettype wire

FILE: rtl/chunk_rms_level_envelope_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_rms_level_envelope_unit: RMS level meter with attack/release envelope
// Samples are accepted one per cycle while the queue has room; each chunk end
// is processed by a sequenced back end that shares one divider and one squarer.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the command queue has room.
// A chunk result takes up to three passes through the bit-serial divider, the
// normalize shifts and up to two runs of 16 squarings, plus any wait behind older
// commands in the queue or on out_beat.ready; a level-reset result goes from
// the idle state straight to the emit state.
// Reset (rst_n low, synchronous) clears the accumulator, envelope, voice flag,
// queue and output, and loads the default configuration.
// ----------------------------------------------------------------------------
module chunk_rms_level_envelope_unit #(
  parameter int MAX_CHUNK_SAMPLES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  crle_in_if.sink                                in_beat,
  crle_out_if.source                             out_beat,
  input  wire logic                              cfg_we,
  input  wire logic [crle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import crle_pkg::*;

  // The sample counter must hold the chunk limit itself; the sum of squares
  // grows by at most 2^30 per sample.
  localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SUM_W = CNT_W + 30;
  localparam int QW    = 2 + SUM_W + CNT_W;

  crle_cfg_t       cfg_r;
  q_stat_t         q_stat;
  logic            q_push, q_pop;
  logic [QW-1:0]   q_wdata, q_rdata;

  // Config regs. The user must write only while the unit is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_hz    <= RATE_RESET;
      cfg_r.attack_ms  <= ATTACK_RESET;
      cfg_r.release_ms <= RELEASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_RATE:    cfg_r.rate_hz    <= cfg_wdata;
        CFG_IDX_ATTACK:  cfg_r.attack_ms  <= cfg_wdata[TAU_W-1:0];
        CFG_IDX_RELEASE: cfg_r.release_ms <= cfg_wdata[TAU_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: squares and accumulates samples at full rate while the queue has
  // room; chunk ends and voice/clear events are queued as commands in order.
  crle_front #(
    .MAX_CNT (MAX_CHUNK_SAMPLES),
    .CNT_W   (CNT_W),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  // The queue decouples the two halves so that samples keep streaming while
  // the back end works through a chunk end.
  crle_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: the dB mapping, envelope and displayed level, with an output
  // register so a waiting result does not stop the back end taking the next command.
  crle_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .q_rdata  (q_rdata),
    .pop      (q_pop),
    .out_beat (out_beat)
  );

endmodule
`default_nettype wire

FILE: verif/chunk_rms_level_envelope_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_rms_level_envelope_unit_tb: self-checking bench for the level meter
// Drives sample, voice and clear beats with random gaps and output stalls.
// A fixed-point predictor of the chunk RMS, dB mapping, envelope and display
// scaling computes each expected level, which is checked against the result
// channel in order. Several register settings are exercised between phases.
// ----------------------------------------------------------------------------
module chunk_rms_level_envelope_unit_tb;
  import crle_pkg::*;

  localparam int MAX_CHUNK  = 4096;
  // Settle time after draining, for back-end work that yields no result.
  localparam int SETTLE_CYC = 400;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  crle_in_if  in_ch();
  crle_out_if out_ch();

  chunk_rms_level_envelope_unit #(.MAX_CHUNK_SAMPLES(MAX_CHUNK)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state, kept at the widths of the block.
  logic [RATE_W-1:0] pr_rate;
  logic [TAU_W-1:0]  pr_attack;
  logic [TAU_W-1:0]  pr_release;
  logic [42:0]       pr_sq_sum;
  logic [12:0]       pr_count;
  logic [16:0]       pr_env;
  logic              pr_voice;

  logic [LEVEL_W-1:0] level_fifo[$];
  int  mismatches;
  int  idle_cycles;
  bit  quiet;          // when set, neither side inserts gaps or stalls

  // log2 of v in Q16: integer part from the top set bit, fraction by
  // repeated squaring of a Q1.30 mantissa.
  function automatic longint unsigned log2_q16(longint unsigned v);
    longint unsigned n, m, frac;
    n = 0;
    frac = 0;
    if (v <= 1) return 0;
    while ((v >> (n + 1)) != 0) n++;
    m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (n << 16) | frac;
  endfunction

  // Smoothing coefficient 1 - exp(-dt/tau) in Q16, with exp taken as
  // (1 - r/65536)^65536 through 16 squarings.
  function automatic longint unsigned smoothing_q16(longint unsigned cnt,
                                                    longint unsigned tau);
    longint unsigned rate, t, r, stp, x;
    rate = (pr_rate == 0) ? 1 : pr_rate;
    t = (tau == 0) ? 1 : tau;
    r = (cnt * 1000 * (64'd1 << 32)) / (rate * t);
    if (r >= (64'd16 << 32)) return 65536;
    stp = r >> 16;
    if (stp == 0) return 0;
    x = (64'd1 << 32) - stp;
    for (int i = 0; i < 16; i++) x = (x * x) >> 32;
    return 65536 - (x >> 16);
  endfunction

  // Closes the current chunk and returns the displayed level.
  function automatic logic [LEVEL_W-1:0] close_chunk();
    longint unsigned mean, lg, norm, a, env, shown;
    mean = longint'(pr_sq_sum) / longint'(pr_count);
    lg = log2_q16(mean);
    norm = 0;
    env = pr_env;
    if (lg > NORM_X0) begin
      norm = ((lg - NORM_X0) * NORM_SLOPE) >> 16;
      if (norm > 65536) norm = 65536;
    end
    if (norm > env) begin
      a = smoothing_q16(pr_count, pr_attack);
      env = env + ((a * (norm - env)) >> 16);
    end else begin
      a = smoothing_q16(pr_count, pr_release);
      env = env - ((a * (env - norm)) >> 16);
    end
    pr_env = env[16:0];
    pr_sq_sum = '0;
    pr_count = '0;
    if (!pr_voice) return '0;
    shown = (32768 * env + (env + 32768) / 2) / (env + 32768);
    return shown[LEVEL_W-1:0];
  endfunction

  // Applies one accepted beat to the predictor.
  function automatic void predict_beat(logic [1:0] kind, logic signed [15:0] smp,
                                       logic ce);
    longint unsigned mag;
    case (kind)
      KIND_SAMPLE: begin
        mag = (smp < 0) ? longint'(-longint'(smp)) : longint'(smp);
        pr_sq_sum = pr_sq_sum + mag * mag;
        pr_count = pr_count + 1;
        if (ce || pr_count >= MAX_CHUNK)
          level_fifo.insert(level_fifo.size(), close_chunk());
      end
      KIND_SPEECH_ON:  pr_voice = 1'b1;
      KIND_SPEECH_OFF: pr_voice = 1'b0;
      default: begin
        pr_env = '0;
        level_fifo.insert(level_fifo.size(), '0);
      end
    endcase
  endfunction

  // Sends one beat, with a random gap first, and waits for its acceptance.
  // Called at a rising edge; leaves valid high on return.
  task automatic send_beat(logic [1:0] kind, logic signed [15:0] smp, logic ce);
    while (!quiet && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.sample    <= smp;
    in_ch.chunk_end <= ce;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_beat(kind, smp, ce);
  endtask

  // Waits until every expected level has arrived and the back end has
  // had time to finish any work that produces no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (level_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only while idle.
  task automatic load_config(logic [RATE_W-1:0] rate, logic [TAU_W-1:0] att,
                             logic [TAU_W-1:0] rel);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    pr_rate = rate;
    cfg_index <= CFG_IDX_ATTACK;
    cfg_wdata <= CFG_DATA_W'(att);
    @(posedge clk);
    pr_attack = att;
    cfg_index <= CFG_IDX_RELEASE;
    cfg_wdata <= CFG_DATA_W'(rel);
    @(posedge clk);
    pr_release = rel;
    cfg_we <= 1'b0;
  endtask

  // Random sample whose loudness spans the whole dB range.
  function automatic logic signed [15:0] rand_sample(int unsigned atten);
    logic signed [15:0] s;
    s = 16'($urandom);
    return s >>> atten;
  endfunction

  // One chunk of random length and loudness.
  task automatic send_chunk(int unsigned max_len);
    int unsigned len, atten;
    len = $urandom_range(max_len, 1);
    atten = $urandom_range(15);
    for (int unsigned i = 0; i < len; i++)
      send_beat(KIND_SAMPLE, rand_sample(atten), i == len - 1);
  endtask

  // Edge cases: full-scale samples of both signs, silence, voice gating
  // and level clear; most chunks hold a single sample, two hold two.
  task automatic test_directed();
    send_beat(KIND_SAMPLE, 16'sh7FFF, 1'b1);     // voice off gates to zero
    send_beat(KIND_SPEECH_ON, 16'sh0000, 1'b0);
    send_beat(KIND_SAMPLE, 16'sh8000, 1'b1);
    send_beat(KIND_SAMPLE, 16'sh7FFF, 1'b1);
    send_beat(KIND_SAMPLE, 16'sh0000, 1'b1);     // zero mean square
    send_beat(KIND_SAMPLE, 16'sh0001, 1'b1);
    send_beat(KIND_SAMPLE, -16'sd1, 1'b0);
    send_beat(KIND_SAMPLE, 16'sh5555, 1'b1);
    send_beat(KIND_SAMPLE, -16'sd21846, 1'b0);
    send_beat(KIND_SAMPLE, 16'sh00B4, 1'b1);     // closes a two-sample chunk
    send_beat(KIND_CLEAR, 16'shFFFF, 1'b1);
    send_beat(KIND_SAMPLE, 16'sh7FFF, 1'b1);
    send_beat(KIND_SPEECH_OFF, 16'sh1234, 1'b1); // fields ignored
    send_beat(KIND_SAMPLE, 16'sh0000, 1'b1);
    send_beat(KIND_SPEECH_ON, 16'sh0000, 1'b0);
    send_beat(KIND_SAMPLE, 16'sh0100, 1'b1);
    send_beat(KIND_CLEAR, 16'sh0000, 1'b0);
    drain();
  endtask

  // Mostly well-formed chunks, with voice toggles and clears mixed in.
  task automatic test_random_traffic(int unsigned n_chunks);
    int unsigned pick;
    for (int unsigned c = 0; c < n_chunks; c++) begin
      pick = $urandom_range(99);
      if (pick < 8)
        send_beat(KIND_SPEECH_ON, 16'($urandom), 1'($urandom));
      else if (pick < 12)
        send_beat(KIND_SPEECH_OFF, 16'($urandom), 1'($urandom));
      else if (pick < 16)
        send_beat(KIND_CLEAR, 16'($urandom), 1'($urandom));
      else if (pick < 30)
        send_chunk(3);
      else
        send_chunk(20);
    end
  endtask

  // The sender holds off until every pending level has come back.
  task automatic test_sender_holdoff();
    for (int i = 0; i < 4; i++) begin
      send_chunk(8);
      in_ch.valid <= 1'b0;
      while (level_fifo.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  // Receiver: random back-pressure unless in a quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 30);
  end

  // Result check against the oldest expected level.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (level_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected level beat: %0d", out_ch.level);
      end else begin
        if (out_ch.level !== level_fifo[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("level mismatch: expected %0d, got %0d",
                     level_fifo[0], out_ch.level);
        end
        void'(level_fifo.pop_front());
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SAMPLE;
    in_ch.sample = '0;
    in_ch.chunk_end = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    pr_rate = RATE_RESET;
    pr_attack = ATTACK_RESET;
    pr_release = RELEASE_RESET;
    pr_sq_sum = '0;
    pr_count = '0;
    pr_env = '0;
    pr_voice = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers first.
    test_directed();
    test_random_traffic(20);
    drain();
    test_sender_holdoff();

    // Zero registers behave as one.
    load_config('0, '0, '0);
    test_random_traffic(15);
    drain();

    // Fastest rate with the slowest envelope.
    load_config(16'd48000, 14'd10000, 14'd10000);
    test_random_traffic(20);
    drain();

    // Slowest rate with the fastest envelope; a stretch without gaps.
    load_config(16'd8000, 14'd1, 14'd1);
    quiet = 1'b1;
    test_random_traffic(20);
    quiet = 1'b0;
    drain();

    // All register bits high.
    load_config(16'hFFFF, 14'h3FFF, 14'h3FFF);
    test_random_traffic(15);
    drain();

    // Random settings within the usual range.
    for (int p = 0; p < 3; p++) begin
      load_config(RATE_W'($urandom_range(48000, 8000)),
                  TAU_W'($urandom_range(10000, 1)),
                  TAU_W'($urandom_range(10000, 1)));
      test_random_traffic(13);
      drain();
    end

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
